/* sv/wwl_pkg.sv */
// Shared types and constants of the word-wrap layout engine.
`default_nettype none

package wwl_pkg;

  // Field widths of the channels.
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned ROW_W      = 3;
  localparam int unsigned COL_W      = 6;
  localparam int unsigned GLYPH_W    = 7;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned LIMIT_W    = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;

  // Depth of the queue between the front and the sequencer.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Register values after reset.
  localparam logic [COL_W-1:0]   LINE_WIDTH_RST = 6'd32;
  localparam logic [LIMIT_W-1:0] LINE_LIMIT_RST = 4'd8;

  // Character codes.
  localparam logic [BYTE_W-1:0]  CHR_END       = 8'h00;
  localparam logic [BYTE_W-1:0]  CHR_NEWLINE   = 8'h0A;
  localparam logic [BYTE_W-1:0]  CHR_SPACE     = 8'h20;
  localparam logic [BYTE_W-1:0]  CHR_FIRST     = 8'h20;
  localparam logic [BYTE_W-1:0]  CHR_LAST      = 8'h7E;
  localparam logic [GLYPH_W-1:0] GLYPH_UNKNOWN = 7'h3F;
  localparam logic [GLYPH_W-1:0] GLYPH_DOT     = 7'h2E;
  localparam logic [GLYPH_W-1:0] GLYPH_SPACE   = 7'h20;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_WIDTH = 2'd0,
    REG_LINE_LIMIT = 2'd1
  } cfg_reg_e;

  // Kinds of result items.
  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE    = 2'd0,
    KIND_LINE_END = 2'd1,
    KIND_DONE     = 2'd2
  } kind_e;

  // Classes of text bytes, decided in the front.
  typedef enum logic [1:0] {
    CLS_END     = 2'd0,
    CLS_NEWLINE = 2'd1,
    CLS_SPACE   = 2'd2,
    CLS_CHAR    = 2'd3
  } byte_class_e;

  // One classified byte in the queue.
  typedef struct packed {
    byte_class_e          cls;
    logic [GLYPH_W-1:0]   glyph;
  } item_t;

  // Head of the queue as seen by the sequencer.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  // One result item.
  typedef struct packed {
    kind_e                kind;
    logic [ROW_W-1:0]     row;
    logic [COL_W-1:0]     column;
    logic [GLYPH_W-1:0]   glyph;
    logic [COUNT_W-1:0]   line_count;
    logic                 last;
  } result_t;

endpackage

`default_nettype wire

/* sv/wwl_if.sv */
// Channel interfaces of the word-wrap layout engine: text in, results out, configuration.
`default_nettype none

interface wwl_text_if;
  logic                        valid;
  logic                        ready;
  logic [wwl_pkg::BYTE_W-1:0]  text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface wwl_result_if;
  logic                         valid;
  logic                         ready;
  wwl_pkg::kind_e               kind;
  logic [wwl_pkg::ROW_W-1:0]    row;
  logic [wwl_pkg::COL_W-1:0]    column;
  logic [wwl_pkg::GLYPH_W-1:0]  glyph;
  logic [wwl_pkg::COUNT_W-1:0]  line_count;
  logic                         last;

  modport source (output valid, output kind, output row, output column, output glyph,
                  output line_count, output last, input ready);
  modport sink   (input valid, input kind, input row, input column, input glyph,
                  input line_count, input last, output ready);
endinterface

interface wwl_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [wwl_pkg::CFG_IDX_W-1:0]   index;
  logic [wwl_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/wwl_front.sv */
// Front of the layout engine: classifies text bytes and queues them for the sequencer.
`default_nettype none

module wwl_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  wwl_text_if.sink              text_i,
  input  logic                  pop_i,
  output wwl_pkg::queue_head_t  head_o
);

  localparam int unsigned PtrW = wwl_pkg::QPTR_W;
  localparam int unsigned CntW = wwl_pkg::QPTR_W + 1;
  localparam logic [CntW-1:0] Depth = CntW'(wwl_pkg::QUEUE_DEPTH);

  wwl_pkg::item_t   slot_q [wwl_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  wwl_pkg::item_t   item_in;
  logic             push;
  logic             pop;

  // Sort the byte into end, newline, space or any other character.
  always_comb begin
    item_in.glyph = wwl_pkg::GLYPH_UNKNOWN;
    if (text_i.text_byte >= wwl_pkg::CHR_FIRST && text_i.text_byte <= wwl_pkg::CHR_LAST) begin
      item_in.glyph = text_i.text_byte[wwl_pkg::GLYPH_W-1:0];
    end
    priority if (text_i.text_byte == wwl_pkg::CHR_END) begin
      item_in.cls = wwl_pkg::CLS_END;
    end else if (text_i.text_byte == wwl_pkg::CHR_NEWLINE) begin
      item_in.cls = wwl_pkg::CLS_NEWLINE;
    end else if (text_i.text_byte == wwl_pkg::CHR_SPACE) begin
      item_in.cls = wwl_pkg::CLS_SPACE;
    end else begin
      item_in.cls = wwl_pkg::CLS_CHAR;
    end
  end

  // Queue control: a transfer pushes, the sequencer pops.
  assign text_i.ready = (count_q != Depth);
  assign push         = text_i.valid && text_i.ready;
  assign pop          = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + PtrW'(1);
    end
    unique case ({push, pop})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_in;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = slot_q[rd_ptr_q];

endmodule

`default_nettype wire

/* sv/wwl_back.sv */
// Back of the layout engine: configuration, word store and the layout sequencer.
`default_nettype none

module wwl_back #(
  parameter int unsigned MAX_COLS = 32,
  parameter int unsigned MAX_ROWS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  wwl_cfg_if.sink               cfg_i,
  input  wwl_pkg::queue_head_t  head_i,
  output logic                  pop_o,
  wwl_result_if.source          result_o
);

  localparam int unsigned ColW   = wwl_pkg::COL_W;
  localparam int unsigned GlyphW = wwl_pkg::GLYPH_W;
  localparam int unsigned AddrW  = $clog2(MAX_COLS);
  localparam int unsigned LenW   = $clog2(MAX_COLS + 1);
  localparam int unsigned RowW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam logic [ColW-1:0] MaxColsC = ColW'(MAX_COLS);
  localparam logic [7:0]      MaxRowsC = 8'(MAX_ROWS);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_FLUSH    = 8'b0000_0010,
    S_PUT      = 8'b0000_0100,
    S_BREAK    = 8'b0000_1000,
    S_DOTS     = 8'b0001_0000,
    S_LINE_END = 8'b0010_0000,
    S_DONE     = 8'b0100_0000,
    S_SPACE    = 8'b1000_0000
  } state_e;

  // What follows the current flush or break.
  typedef enum logic [2:0] {
    CTX_END   = 3'd0,
    CTX_NL    = 3'd1,
    CTX_SP    = 3'd2,
    CTX_PLAIN = 3'd3,
    CTX_STORE = 3'd4
  } ctx_e;

  state_e                        state_q, state_d;
  ctx_e                          ctx_q, ctx_d;
  logic [ColW-1:0]               lw_q, lw_d;
  logic [wwl_pkg::LIMIT_W-1:0]   ll_q, ll_d;
  logic [LenW-1:0]               wl_q, wl_d;
  logic [AddrW-1:0]              k_q, k_d;
  logic [RowW-1:0]               row_q, row_d;
  logic [ColW-1:0]               col_q, col_d;
  logic                          placed_q, placed_d;
  logic                          ovf_q, ovf_d;
  logic                          seen_q, seen_d;
  logic [GlyphW-1:0]             ch_q, ch_d;
  logic [ColW-1:0]               tr_col_q, tr_col_d;
  logic [ColW-1:0]               tr_end_q, tr_end_d;
  logic                          ov_q;
  wwl_pkg::result_t              out_q;

  logic [GlyphW-1:0]             word_mem [MAX_COLS];
  logic [GlyphW-1:0]             rd_q;
  logic                          we;

  logic                          bad;
  logic [7:0]                    avail;
  logic                          row_full;
  logic                          store_over;
  logic                          last_k;
  logic [ColW-1:0]               next_col;
  logic                          flush_last;
  logic [ColW-1:0]               lw_m3;
  logic [ColW-1:0]               tr_start;
  logic [6:0]                    tr_sum;
  logic [ColW-1:0]               tr_end;
  logic [7:0]                    done_cnt;
  logic                          cfg_fire;
  logic                          out_free;
  logic                          emit;
  logic                          fire;
  wwl_pkg::result_t              emit_res;

  // Layout conditions derived from the current state and registers.
  assign bad        = (lw_q == '0) || (lw_q > MaxColsC) || (ll_q == '0);
  assign avail      = (8'(ll_q) > MaxRowsC) ? MaxRowsC : 8'(ll_q);
  assign row_full   = (8'(row_q) + 8'd1) >= avail;
  assign store_over = (8'(col_q) + 8'(wl_q) + 8'd1) > 8'(lw_q);
  assign last_k     = (LenW'(k_q) + LenW'(1)) == wl_q;
  assign next_col   = col_q + ColW'(1);
  assign flush_last = last_k && ((ctx_q == CTX_PLAIN) ||
                                 ((ctx_q == CTX_SP) && (next_col >= lw_q)));
  assign done_cnt   = (bad || !seen_q) ? 8'd0 : (ovf_q ? avail : 8'(row_q) + 8'd1);

  // Dots start at min(column, width-3) and are clipped to the line width.
  assign lw_m3    = lw_q - ColW'(3);
  assign tr_start = (lw_q >= ColW'(3)) ? ((col_q < lw_m3) ? col_q : lw_m3) : '0;
  assign tr_sum   = 7'(tr_start) + 7'd3;
  assign tr_end   = (tr_sum > 7'(lw_q)) ? lw_q : tr_sum[ColW-1:0];

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;

  // The output register takes a new result whenever it is empty or being drained.
  assign out_free = !ov_q || result_o.ready;
  assign fire     = emit && out_free;

  // Layout sequencer.
  always_comb begin
    state_d  = state_q;
    ctx_d    = ctx_q;
    lw_d     = lw_q;
    ll_d     = ll_q;
    wl_d     = wl_q;
    k_d      = k_q;
    row_d    = row_q;
    col_d    = col_q;
    placed_d = placed_q;
    ovf_d    = ovf_q;
    seen_d   = seen_q;
    ch_d     = ch_q;
    tr_col_d = tr_col_q;
    tr_end_d = tr_end_q;
    pop_o    = 1'b0;
    we       = 1'b0;
    emit     = 1'b0;
    emit_res.kind       = wwl_pkg::KIND_WRITE;
    emit_res.row        = wwl_pkg::ROW_W'(row_q);
    emit_res.column     = col_q;
    emit_res.glyph      = '0;
    emit_res.line_count = '0;
    emit_res.last       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          unique case (head_i.item.cls)
            wwl_pkg::CLS_END: begin
              if (bad || !seen_q || ovf_q) begin
                state_d = S_DONE;
              end else begin
                ctx_d   = CTX_END;
                k_d     = '0;
                state_d = (wl_q == '0) ? S_LINE_END : S_FLUSH;
              end
            end
            wwl_pkg::CLS_NEWLINE, wwl_pkg::CLS_SPACE: begin
              seen_d = 1'b1;
              if (!bad && !ovf_q) begin
                placed_d = 1'b0;
                k_d      = '0;
                if (head_i.item.cls == wwl_pkg::CLS_NEWLINE) begin
                  ctx_d   = CTX_NL;
                  state_d = (wl_q == '0) ? S_BREAK : S_FLUSH;
                end else begin
                  ctx_d   = CTX_SP;
                  state_d = (wl_q == '0) ? S_SPACE : S_FLUSH;
                end
              end
            end
            wwl_pkg::CLS_CHAR: begin
              seen_d = 1'b1;
              if (!bad && !ovf_q) begin
                if (placed_q || (col_q == '0)) begin
                  // The word is already on the line, or starts a fresh one.
                  placed_d = 1'b1;
                  ch_d     = head_i.item.glyph;
                  ctx_d    = CTX_PLAIN;
                  state_d  = S_PUT;
                end else begin
                  // Buffer the character; move the word down once it no longer fits.
                  we   = 1'b1;
                  wl_d = wl_q + LenW'(1);
                  if (store_over) begin
                    ctx_d   = CTX_STORE;
                    state_d = S_BREAK;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_PUT, S_FLUSH: begin
        if (col_q >= lw_q) begin
          // The line is full: wrap before the character, or truncate.
          if (row_full) begin
            tr_col_d = tr_start;
            tr_end_d = tr_end;
            state_d  = S_DOTS;
          end else begin
            emit          = 1'b1;
            emit_res.kind = wwl_pkg::KIND_LINE_END;
            if (fire) begin
              row_d = row_q + RowW'(1);
              col_d = '0;
            end
          end
        end else begin
          emit           = 1'b1;
          emit_res.glyph = (state_q == S_FLUSH) ? rd_q : ch_q;
          emit_res.last  = (state_q == S_FLUSH) ? flush_last : 1'b1;
          if (fire) begin
            col_d = next_col;
            if (state_q == S_PUT) begin
              state_d = S_IDLE;
            end else if (last_k) begin
              wl_d = '0;
              unique case (ctx_q)
                CTX_END: state_d = S_LINE_END;
                CTX_NL:  state_d = S_BREAK;
                CTX_SP:  state_d = S_SPACE;
                default: state_d = S_IDLE;
              endcase
            end else begin
              k_d = k_q + AddrW'(1);
            end
          end
        end
      end

      S_BREAK: begin
        if (row_full) begin
          tr_col_d = tr_start;
          tr_end_d = tr_end;
          state_d  = S_DOTS;
        end else begin
          emit          = 1'b1;
          emit_res.kind = wwl_pkg::KIND_LINE_END;
          emit_res.last = (ctx_q == CTX_NL);
          if (fire) begin
            row_d = row_q + RowW'(1);
            col_d = '0;
            if (ctx_q == CTX_STORE) begin
              placed_d = 1'b1;
              ctx_d    = CTX_PLAIN;
              k_d      = '0;
              state_d  = S_FLUSH;
            end else begin
              state_d = S_IDLE;
            end
          end
        end
      end

      S_DOTS: begin
        if (tr_col_q < tr_end_q) begin
          emit            = 1'b1;
          emit_res.column = tr_col_q;
          emit_res.glyph  = wwl_pkg::GLYPH_DOT;
          if (fire) begin
            tr_col_d = tr_col_q + ColW'(1);
          end
        end else begin
          // Close the last row; the rest of the text is swallowed.
          emit            = 1'b1;
          emit_res.kind   = wwl_pkg::KIND_LINE_END;
          emit_res.column = tr_end_q;
          emit_res.last   = (ctx_q != CTX_END);
          if (fire) begin
            ovf_d    = 1'b1;
            wl_d     = '0;
            placed_d = 1'b0;
            state_d  = (ctx_q == CTX_END) ? S_DONE : S_IDLE;
          end
        end
      end

      S_LINE_END: begin
        emit          = 1'b1;
        emit_res.kind = wwl_pkg::KIND_LINE_END;
        if (fire) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        emit                = 1'b1;
        emit_res.kind       = wwl_pkg::KIND_DONE;
        emit_res.row        = '0;
        emit_res.column     = '0;
        emit_res.line_count = wwl_pkg::COUNT_W'(done_cnt);
        emit_res.last       = 1'b1;
        if (fire) begin
          wl_d     = '0;
          row_d    = '0;
          col_d    = '0;
          placed_d = 1'b0;
          ovf_d    = 1'b0;
          seen_d   = 1'b0;
          state_d  = S_IDLE;
        end
      end

      S_SPACE: begin
        if ((col_q != '0) && (col_q < lw_q)) begin
          emit           = 1'b1;
          emit_res.glyph = wwl_pkg::GLYPH_SPACE;
          emit_res.last  = 1'b1;
          if (fire) begin
            col_d   = next_col;
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A register write starts the layout afresh.
    if (cfg_fire) begin
      unique case (cfg_i.index)
        wwl_pkg::REG_LINE_WIDTH: begin
          lw_d     = cfg_i.data[ColW-1:0];
          wl_d     = '0;
          row_d    = '0;
          col_d    = '0;
          placed_d = 1'b0;
          ovf_d    = 1'b0;
          seen_d   = 1'b0;
        end
        wwl_pkg::REG_LINE_LIMIT: begin
          ll_d     = cfg_i.data[wwl_pkg::LIMIT_W-1:0];
          wl_d     = '0;
          row_d    = '0;
          col_d    = '0;
          placed_d = 1'b0;
          ovf_d    = 1'b0;
          seen_d   = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ctx_q    <= CTX_PLAIN;
      lw_q     <= wwl_pkg::LINE_WIDTH_RST;
      ll_q     <= wwl_pkg::LINE_LIMIT_RST;
      wl_q     <= '0;
      k_q      <= '0;
      row_q    <= '0;
      col_q    <= '0;
      placed_q <= 1'b0;
      ovf_q    <= 1'b0;
      seen_q   <= 1'b0;
      tr_col_q <= '0;
      tr_end_q <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      ctx_q    <= ctx_d;
      lw_q     <= lw_d;
      ll_q     <= ll_d;
      wl_q     <= wl_d;
      k_q      <= k_d;
      row_q    <= row_d;
      col_q    <= col_d;
      placed_q <= placed_d;
      ovf_q    <= ovf_d;
      seen_q   <= seen_d;
      tr_col_q <= tr_col_d;
      tr_end_q <= tr_end_d;
      if (fire) begin
        ov_q <= 1'b1;
      end else if (result_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ch_q <= ch_d;
    if (fire) begin
      out_q <= emit_res;
    end
  end

  // Word store; the read address runs one step ahead so the data is ready in the flush.
  always_ff @(posedge clk_i) begin
    if (we) begin
      word_mem[wl_q[AddrW-1:0]] <= head_i.item.glyph;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= word_mem[k_d];
  end

  assign result_o.valid      = ov_q;
  assign result_o.kind       = out_q.kind;
  assign result_o.row        = out_q.row;
  assign result_o.column     = out_q.column;
  assign result_o.glyph      = out_q.glyph;
  assign result_o.line_count = out_q.line_count;
  assign result_o.last       = out_q.last;

endmodule

`default_nettype wire

/* sv/word_wrap_text_layout_top.sv */
// Top level of the greedy word-wrap layout engine: byte queue in front, layout sequencer behind.
// A transferred byte waits in the queue until the idle sequencer pops it; its results enter the
// output register. One result per cycle while the output is drained; a byte is popped in a dispatch
// step of its own, and a dropped space or a truncation decision takes a further step with no result.
// Reset (asynchronous, active low) empties the queue, clears the layout and loads line_width 32
// and line_limit 8; the word store is not cleared, as only written entries are ever read.
`default_nettype none

module word_wrap_text_layout_top #(
  parameter int unsigned MAX_COLS = 32,
  parameter int unsigned MAX_ROWS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  wwl_cfg_if.sink       cfg_i,
  wwl_text_if.sink      text_i,
  wwl_result_if.source  result_o
);

  wwl_pkg::queue_head_t head;
  logic                 pop;

  // Byte classification and queue.
  wwl_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .text_i (text_i),
    .pop_i  (pop),
    .head_o (head)
  );

  // Layout sequencer with word store and output register.
  wwl_back #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .head_i   (head),
    .pop_o    (pop),
    .result_o (result_o)
  );

  // The sequencer only takes a byte that the queue holds.
  a_pop_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid)
    else $error("sequencer popped an empty queue");

  // The text channel only stalls while the queue holds bytes.
  a_stall_means_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !text_i.ready |-> head.valid)
    else $error("text channel stalled with an empty queue");

  // A done result always closes the results of its byte.
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.ready && (result_o.kind == wwl_pkg::KIND_DONE))
      |-> result_o.last)
    else $error("done result transferred without last");

endmodule

`default_nettype wire
